@@ rtl/core/cit_pkg.sv @@
// Shared types, codes and helpers for the CAN id capture table.
package cit_pkg;

	localparam int unsigned CIT_MAX_IDS = 64;
	localparam int unsigned CIT_NUM_BUS = 2;
	localparam int unsigned CIT_MAX_LEN = 8;
	localparam int unsigned CIT_IDS_W   = 7;

	typedef enum logic [1:0] {
		REQ_CAPTURE = 2'd0,
		REQ_READ    = 2'd1,
		REQ_CLEAR   = 2'd2,
		REQ_UNUSED  = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		OUT_UPDATED  = 2'd0,
		OUT_APPENDED = 2'd1,
		OUT_DROPPED  = 2'd2,
		OUT_NONE     = 2'd3
	} outcome_t;

	typedef struct packed {
		req_type_t   req_type;
		logic        bus_index;
		logic [28:0] frame_id;
		logic [3:0]  data_len;
		logic [63:0] payload;
		logic [31:0] timestamp;
		logic [5:0]  slot_index;
	} cit_req_t;

	typedef struct packed {
		outcome_t    capture_outcome;
		logic        slot_valid;
		logic [28:0] slot_id;
		logic [31:0] slot_count;
		logic [31:0] slot_age;
		logic [3:0]  slot_len;
		logic [63:0] slot_payload;
		logic [6:0]  ids_tracked;
		logic [31:0] total_frames;
		logic [31:0] dropped_frames;
	} cit_rsp_t;

	typedef struct packed {
		logic [28:0] id;
		logic [31:0] count;
		logic [31:0] seen_ts;
		logic [3:0]  len;
		logic [63:0] payload;
	} entry_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic rd_issue;
		logic hit_wr;
		logic append;
		logic drop;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic pend;
		logic scan_end;
		logic full;
		logic out_busy;
	} stat_t;

	function automatic logic [63:0] keep_bytes(input logic [63:0] d, input logic [3:0] len);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < CIT_MAX_LEN; i++) begin
			if (4'(i) < len) begin
				m[i*8 +: 8] = 8'hFF;
			end
		end
		return d & m;
	endfunction

endpackage

@@ rtl/core/cit_stream_if.sv @@
// Valid/ready stream channel carrying one beat of type T.
interface cit_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/core/cit_ctrl.sv @@
// Controller state machine sequencing accept, table search, read and result.
module cit_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  cit_pkg::req_type_t  in_type,
	output logic                in_ready,
	input  cit_pkg::stat_t      stat,
	output cit_pkg::cmd_t       cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_RD,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					unique case (in_type)
						cit_pkg::REQ_CAPTURE: state_d = ST_SEARCH;
						cit_pkg::REQ_READ:    state_d = ST_RD;
						default:              state_d = ST_FINISH;
					endcase
				end
			end
			ST_SEARCH: begin
				if (stat.hit) begin
					cmd.hit_wr = 1'b1;
					state_d    = ST_FINISH;
				end else if (stat.pend || !stat.scan_end) begin
					cmd.scan = 1'b1;
				end else begin
					if (stat.full) begin
						cmd.drop = 1'b1;
					end else begin
						cmd.append = 1'b1;
					end
					state_d = ST_FINISH;
				end
			end
			ST_RD: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_FINISH;
			end
			ST_FINISH: begin
				if (!stat.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/core/cit_datapath.sv @@
// Datapath: slot memory, per-bus counters, search pointer and result register.
module cit_datapath #(
	parameter int unsigned MAX_IDS = cit_pkg::CIT_MAX_IDS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cit_pkg::cit_req_t in_data,
	output cit_pkg::cit_rsp_t out_data,
	output logic              out_valid,
	input  logic              out_ready,
	input  cit_pkg::cmd_t     cmd,
	output cit_pkg::stat_t    stat
);

	localparam int unsigned SW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
	localparam int unsigned FW = $clog2(MAX_IDS + 1);
	localparam int unsigned NB = cit_pkg::CIT_NUM_BUS;

	cit_pkg::entry_t   mem_q [NB][MAX_IDS];
	cit_pkg::cit_req_t req_q;
	cit_pkg::outcome_t outcome_q;
	cit_pkg::entry_t   rd_s1;
	logic              rd_v_s1;
	logic [SW-1:0]     ptr_s1;
	logic [FW-1:0]     ptr_q;
	logic [FW-1:0]     fill_q [NB];
	logic [31:0]       tot_q [NB];
	logic [31:0]       drop_q [NB];
	cit_pkg::cit_rsp_t rsp_q;
	logic              rsp_v_q;

	logic              b;
	logic [FW-1:0]     fill_b;
	logic              scan_rd;
	logic              rd_en;
	logic [SW-1:0]     rd_slot;
	logic              wr_en;
	logic [SW-1:0]     wr_slot;
	cit_pkg::entry_t   wr_entry;
	logic [3:0]        len_clamp;
	cit_pkg::cit_req_t req_d;
	logic              read_ok;
	logic [31:0]       age;
	cit_pkg::cit_rsp_t rsp_d;

	assign b       = req_q.bus_index;
	assign fill_b  = fill_q[b];

	assign stat.hit      = rd_v_s1 && (rd_s1.id == req_q.frame_id);
	assign stat.pend     = rd_v_s1;
	assign stat.scan_end = (ptr_q >= fill_b);
	assign stat.full     = (32'(fill_b) >= MAX_IDS);
	assign stat.out_busy = rsp_v_q && !out_ready;

	assign scan_rd = cmd.scan && !stat.scan_end;
	assign rd_en   = scan_rd || cmd.rd_issue;
	assign rd_slot = cmd.rd_issue ? SW'(req_q.slot_index) : ptr_q[SW-1:0];

	assign wr_en   = cmd.hit_wr || cmd.append;
	assign wr_slot = cmd.hit_wr ? ptr_s1 : fill_b[SW-1:0];

	always_comb begin
		wr_entry         = '0;
		wr_entry.id      = req_q.frame_id;
		wr_entry.count   = cmd.hit_wr ? (rd_s1.count + 32'd1) : 32'd1;
		wr_entry.seen_ts = req_q.timestamp;
		wr_entry.len     = req_q.data_len;
		wr_entry.payload = req_q.payload;
	end

	assign len_clamp = (32'(in_data.data_len) > cit_pkg::CIT_MAX_LEN) ?
		4'(cit_pkg::CIT_MAX_LEN) : in_data.data_len;

	always_comb begin
		req_d          = in_data;
		req_d.data_len = len_clamp;
		req_d.payload  = cit_pkg::keep_bytes(in_data.payload, len_clamp);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[b][wr_slot] <= wr_entry;
		end
		if (rd_en) begin
			rd_s1  <= mem_q[b][rd_slot];
			ptr_s1 <= rd_slot;
		end
		if (cmd.load) begin
			req_q <= req_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1   <= 1'b0;
			ptr_q     <= '0;
			outcome_q <= cit_pkg::OUT_NONE;
			for (int i = 0; i < NB; i++) begin
				fill_q[i] <= '0;
				tot_q[i]  <= '0;
				drop_q[i] <= '0;
			end
		end else begin
			rd_v_s1 <= scan_rd;
			if (scan_rd) begin
				ptr_q <= ptr_q + FW'(1);
			end
			if (cmd.load) begin
				ptr_q     <= '0;
				outcome_q <= cit_pkg::OUT_NONE;
				if (in_data.req_type == cit_pkg::REQ_CAPTURE) begin
					tot_q[in_data.bus_index] <= tot_q[in_data.bus_index] + 32'd1;
				end
				if (in_data.req_type == cit_pkg::REQ_CLEAR) begin
					for (int i = 0; i < NB; i++) begin
						fill_q[i] <= '0;
						tot_q[i]  <= '0;
						drop_q[i] <= '0;
					end
				end
			end
			if (cmd.hit_wr) begin
				outcome_q <= cit_pkg::OUT_UPDATED;
			end
			if (cmd.append) begin
				outcome_q <= cit_pkg::OUT_APPENDED;
				fill_q[b] <= fill_b + FW'(1);
			end
			if (cmd.drop) begin
				outcome_q <= cit_pkg::OUT_DROPPED;
				drop_q[b] <= drop_q[b] + 32'd1;
			end
		end
	end

	assign read_ok = (req_q.req_type == cit_pkg::REQ_READ) &&
		(32'(req_q.slot_index) < 32'(fill_b)) && (32'(req_q.slot_index) < MAX_IDS);
	assign age = (req_q.timestamp >= rd_s1.seen_ts) ?
		(req_q.timestamp - rd_s1.seen_ts) : 32'd0;

	always_comb begin
		rsp_d                 = '0;
		rsp_d.capture_outcome = outcome_q;
		if (read_ok) begin
			rsp_d.slot_valid   = 1'b1;
			rsp_d.slot_id      = rd_s1.id;
			rsp_d.slot_count   = rd_s1.count;
			rsp_d.slot_age     = age;
			rsp_d.slot_len     = rd_s1.len;
			rsp_d.slot_payload = rd_s1.payload;
		end
		rsp_d.ids_tracked    = cit_pkg::CIT_IDS_W'(fill_b);
		rsp_d.total_frames   = tot_q[b];
		rsp_d.dropped_frames = drop_q[b];
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_v_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_v_q <= 1'b1;
		end else if (out_ready) begin
			rsp_v_q <= 1'b0;
		end
	end

	assign out_data  = rsp_q;
	assign out_valid = rsp_v_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q[0] <= FW'(MAX_IDS)) && (fill_q[1] <= FW'(MAX_IDS)))
		else $error("fill level above table size");

	a_hit_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.hit_wr |-> rd_v_s1)
		else $error("slot update without read data");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && (in_data.req_type == cit_pkg::REQ_CLEAR) |=>
		(fill_q[0] == '0) && (fill_q[1] == '0) && (tot_q[0] == '0) && (drop_q[1] == '0))
		else $error("clear left counters set");

	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_v_q) |-> $past(cmd.finish))
		else $error("result beat without finish");

endmodule

@@ rtl/core/can_id_capture_table.sv @@
// Top level of the CAN id capture table: controller plus datapath.
//
// Two stream channels: req takes request beats (capture, read slot, clear),
// rsp gives exactly one result beat per request, in order.
// Each bus has a table of up to MAX_IDS distinct ids kept in one slot memory
// with a single registered read port; a capture walks the bus's filled slots
// one per cycle through that port, comparing the previous cycle's read data.
// Path through the controller: a capture searches the filled slots until a hit
// or the end and then goes to the finish state, a read issues its slot read and
// then finishes, and a clear or unused request goes straight to finish, where
// the result is registered once the output register is free.
// One request is worked at a time; req.ready is high only while idle, so with
// rsp ready a new request is taken only once the last one has finished, and
// the sustained rate is set by the slot walk for captures.
// A finished result sits in the output register; the next request is taken
// while it waits. If rsp stalls, the following result waits in the controller
// until the output register empties.
// Reset clears fill levels, totals and drop counts of both buses at once.
// Slot contents are not cleared: entries at or above the fill level are never
// reported.
module can_id_capture_table #(
	parameter int unsigned MAX_IDS = cit_pkg::CIT_MAX_IDS
) (
	input  logic         clk,
	input  logic         arst_n,
	cit_stream_if.sink   req,
	cit_stream_if.source rsp
);

	cit_pkg::cmd_t  cmd;
	cit_pkg::stat_t stat;

	cit_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_type  (req.data.req_type),
		.in_ready (req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cit_datapath #(
		.MAX_IDS (MAX_IDS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (req.data),
		.out_data  (rsp.data),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

@@ verif/tb_can_id_capture_table.sv @@
// Testbench for can_id_capture_table: directed rows, then random episodes checked on a shadow table.
`timescale 1ns / 100ps

module tb_can_id_capture_table;
	import cit_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int RAND_ITEMS = 900;

	typedef struct {
		cit_req_t rq;
		bit       pinned;
		cit_rsp_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cit_stream_if #(.T(cit_req_t)) req_if ();
	cit_stream_if #(.T(cit_rsp_t)) rsp_if ();

	can_id_capture_table u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	always #10 clk = ~clk;

	// shadow of both bus tables
	logic [28:0] tab_id    [2][CIT_MAX_IDS];
	logic [31:0] tab_cnt   [2][CIT_MAX_IDS];
	logic [31:0] tab_seen  [2][CIT_MAX_IDS];
	logic [3:0]  tab_len   [2][CIT_MAX_IDS];
	logic [63:0] tab_pay   [2][CIT_MAX_IDS];
	int unsigned fill_lvl  [2];
	logic [31:0] frames_tot[2];
	logic [31:0] drops_tot [2];

	cit_rsp_t    pending_rsp_q[$];
	dir_row_t    dir_rows[$];
	logic [28:0] id_pool[8];
	logic [31:0] tick;

	bit req_idle_en;
	bit rsp_idle_en;
	int stall_left;
	int idle_cycles;
	int err_cnt;
	int n_sent, n_results;
	int n_appended, n_updated, n_dropped, n_reads, n_reads_hit, n_clears;

	function automatic cit_req_t mk_req(req_type_t t, logic b, logic [28:0] id, logic [3:0] len,
			logic [63:0] pay, logic [31:0] ts, logic [5:0] idx);
		cit_req_t rq;
		rq.req_type   = t;
		rq.bus_index  = b;
		rq.frame_id   = id;
		rq.data_len   = len;
		rq.payload    = pay;
		rq.timestamp  = ts;
		rq.slot_index = idx;
		return rq;
	endfunction

	function automatic cit_rsp_t mk_rsp(outcome_t o, logic v, logic [28:0] id, logic [31:0] cnt,
			logic [31:0] age, logic [3:0] len, logic [63:0] pay, logic [6:0] ids,
			logic [31:0] tot, logic [31:0] drp);
		cit_rsp_t r;
		r.capture_outcome = o;
		r.slot_valid      = v;
		r.slot_id         = id;
		r.slot_count      = cnt;
		r.slot_age        = age;
		r.slot_len        = len;
		r.slot_payload    = pay;
		r.ids_tracked     = ids;
		r.total_frames    = tot;
		r.dropped_frames  = drp;
		return r;
	endfunction

	function automatic cit_rsp_t capture_table_step(input cit_req_t rq);
		cit_rsp_t    r;
		logic [3:0]  len;
		logic [63:0] keep;
		int          b;
		int          n;
		int          hit;
		r = '0;
		r.capture_outcome = OUT_NONE;
		b = rq.bus_index;
		len = (rq.data_len > 4'd8) ? 4'd8 : rq.data_len;
		keep = '0;
		for (int k = 0; k < 8; k++) begin
			if (k < len) keep[k*8 +: 8] = 8'hFF;
		end
		case (rq.req_type)
		REQ_CAPTURE: begin
			n = fill_lvl[b];
			hit = -1;
			frames_tot[b] = frames_tot[b] + 32'd1;
			for (int k = 0; k < n; k++) begin
				if (hit < 0 && tab_id[b][k] == rq.frame_id) hit = k;
			end
			if (hit >= 0) begin
				tab_len[b][hit]  = len;
				tab_pay[b][hit]  = rq.payload & keep;
				tab_seen[b][hit] = rq.timestamp;
				tab_cnt[b][hit]  = tab_cnt[b][hit] + 32'd1;
				r.capture_outcome = OUT_UPDATED;
				n_updated++;
			end else if (n >= CIT_MAX_IDS) begin
				drops_tot[b] = drops_tot[b] + 32'd1;
				r.capture_outcome = OUT_DROPPED;
				n_dropped++;
			end else begin
				tab_id[b][n]   = rq.frame_id;
				tab_len[b][n]  = len;
				tab_pay[b][n]  = rq.payload & keep;
				tab_seen[b][n] = rq.timestamp;
				tab_cnt[b][n]  = 32'd1;
				fill_lvl[b]    = n + 1;
				r.capture_outcome = OUT_APPENDED;
				n_appended++;
			end
		end
		REQ_READ: begin
			n_reads++;
			if (rq.slot_index < fill_lvl[b]) begin
				n_reads_hit++;
				r.slot_valid   = 1'b1;
				r.slot_id      = tab_id[b][rq.slot_index];
				r.slot_count   = tab_cnt[b][rq.slot_index];
				r.slot_age     = (rq.timestamp >= tab_seen[b][rq.slot_index]) ?
						rq.timestamp - tab_seen[b][rq.slot_index] : 32'd0;
				r.slot_len     = tab_len[b][rq.slot_index];
				r.slot_payload = tab_pay[b][rq.slot_index];
			end
		end
		REQ_CLEAR: begin
			n_clears++;
			for (int k = 0; k < 2; k++) begin
				fill_lvl[k]   = 0;
				frames_tot[k] = '0;
				drops_tot[k]  = '0;
			end
		end
		default: ;
		endcase
		r.ids_tracked    = 7'(fill_lvl[b]);
		r.total_frames   = frames_tot[b];
		r.dropped_frames = drops_tot[b];
		return r;
	endfunction

	function automatic void cmp_field(input string nm, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			err_cnt++;
			if (err_cnt <= 30)
				$display("%0t mismatch %s: expected %h, actual %h", $time, nm, want, got);
		end
	endfunction

	task automatic drive_req(input cit_req_t rq, input bit pinned, input cit_rsp_t want);
		cit_rsp_t exp_rsp;
		int       r;
		int       gap;
		req_if.valid <= 1'b1;
		req_if.data  <= rq;
		do @(posedge clk); while (!req_if.ready);
		exp_rsp = capture_table_step(rq);
		pending_rsp_q.push_back(pinned ? want : exp_rsp);
		n_sent++;
		gap = 0;
		if (req_idle_en) begin
			r = $urandom_range(0, 99);
			if (r >= 92) gap = $urandom_range(10, 40);
			else if (r >= 60) gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [28:0] fresh_id();
		if ($urandom_range(0, 1) != 0) return 29'($urandom_range(0, 2047));
		return 29'($urandom);
	endfunction

	// one random beat; mode 0 reuses a small id pool, 1 floods new ids, 2 mixes both
	task automatic rand_item(input int mode, input int bus_sel);
		cit_req_t rq;
		int       r;
		int       fl;
		int       b;
		if (bus_sel < 0) b = $urandom_range(0, 1);
		else b = ($urandom_range(0, 9) < 8) ? bus_sel : (bus_sel ^ 1);
		rq = mk_req(REQ_READ, 1'(b), fresh_id(), 4'($urandom), {$urandom, $urandom},
				$urandom, 6'($urandom));
		fl = fill_lvl[b];
		tick += $urandom_range(0, 40);
		r = $urandom_range(0, 99);
		if (r < ((mode == 1) ? 78 : 65)) begin
			rq.req_type = REQ_CAPTURE;
			if ($urandom_range(0, 9) != 0) rq.timestamp = tick;
			if (mode == 0 || (mode == 2 && $urandom_range(0, 1) == 0))
				rq.frame_id = id_pool[$urandom_range(0, 7)];
			else if (mode == 1 && fl > 0 && $urandom_range(0, 6) == 0)
				rq.frame_id = tab_id[b][$urandom_range(0, fl - 1)];
		end else if (r < 93 || (r >= 97 && mode == 1)) begin
			if (fl > 0 && $urandom_range(0, 4) != 0) rq.slot_index = 6'($urandom_range(0, fl - 1));
			if ($urandom_range(0, 6) != 0) rq.timestamp = tick + $urandom_range(0, 500);
		end else if (r < 97) begin
			rq.req_type = REQ_UNUSED;
		end else begin
			rq.req_type = REQ_CLEAR;
		end
		drive_req(rq, 1'b0, '0);
	endtask

	// response side: random stalls, sometimes long
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			rsp_if.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!rsp_idle_en || $urandom_range(0, 99) < 70) begin
			rsp_if.ready <= 1'b1;
		end else begin
			rsp_if.ready <= 1'b0;
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
					$urandom_range(0, 3);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			n_results++;
			if (pending_rsp_q.size() == 0) begin
				err_cnt++;
				$display("%0t unexpected result beat: expected none, actual %h", $time, rsp_if.data);
			end else begin
				cmp_field("capture_outcome", pending_rsp_q[0].capture_outcome,
						rsp_if.data.capture_outcome);
				cmp_field("slot_valid", pending_rsp_q[0].slot_valid, rsp_if.data.slot_valid);
				cmp_field("slot_id", pending_rsp_q[0].slot_id, rsp_if.data.slot_id);
				cmp_field("slot_count", pending_rsp_q[0].slot_count, rsp_if.data.slot_count);
				cmp_field("slot_age", pending_rsp_q[0].slot_age, rsp_if.data.slot_age);
				cmp_field("slot_len", pending_rsp_q[0].slot_len, rsp_if.data.slot_len);
				cmp_field("slot_payload", pending_rsp_q[0].slot_payload, rsp_if.data.slot_payload);
				cmp_field("ids_tracked", pending_rsp_q[0].ids_tracked, rsp_if.data.ids_tracked);
				cmp_field("total_frames", pending_rsp_q[0].total_frames, rsp_if.data.total_frames);
				cmp_field("dropped_frames", pending_rsp_q[0].dropped_frames,
						rsp_if.data.dropped_frames);
				void'(pending_rsp_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t timeout, %0d results still pending", $time, pending_rsp_q.size());
				$display("[can_id_capture_table] ERROR");
				$finish;
			end
		end
	end

	initial begin : stim
		localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
		localparam logic [63:0] PAT  = 64'h0123_4567_89AB_CDEF;
		int n_rand;
		int mode;
		int bus_sel;
		int ep_len;
		bit first_ep;
		req_if.valid <= 1'b0;
		req_if.data  <= '0;
		req_idle_en = 1'b1;
		rsp_idle_en = 1'b1;
		tick = '0;
		for (int k = 0; k < 2; k++) begin
			fill_lvl[k] = 0;
			frames_tot[k] = '0;
			drops_tot[k] = '0;
		end

		dir_rows.push_back('{mk_req(REQ_READ, 1'b0, 29'd0, 4'd0, 64'd0, 32'd0, 6'd0), 1'b1,
				mk_rsp(OUT_NONE, 1'b0, '0, '0, '0, '0, '0, 7'd0, 32'd0, 32'd0)});
		dir_rows.push_back('{mk_req(REQ_UNUSED, 1'b1, 29'h1FFF_FFFF, 4'hF, ONES, 32'hFFFF_FFFF,
				6'h3F), 1'b1, mk_rsp(OUT_NONE, 1'b0, '0, '0, '0, '0, '0, 7'd0, 32'd0, 32'd0)});
		dir_rows.push_back('{mk_req(REQ_CAPTURE, 1'b0, 29'd0, 4'd0, ONES, 32'd100, 6'd0), 1'b1,
				mk_rsp(OUT_APPENDED, 1'b0, '0, '0, '0, '0, '0, 7'd1, 32'd1, 32'd0)});
		dir_rows.push_back('{mk_req(REQ_CAPTURE, 1'b0, 29'h1FFF_FFFF, 4'hF, ONES, 32'hFFFF_FFFF,
				6'd0), 1'b1, mk_rsp(OUT_APPENDED, 1'b0, '0, '0, '0, '0, '0, 7'd2, 32'd2, 32'd0)});
		dir_rows.push_back('{mk_req(REQ_READ, 1'b0, 29'd0, 4'd0, 64'd0, 32'd0, 6'd1), 1'b1,
				mk_rsp(OUT_NONE, 1'b1, 29'h1FFF_FFFF, 32'd1, 32'd0, 4'd8, ONES, 7'd2, 32'd2,
				32'd0)});
		dir_rows.push_back('{mk_req(REQ_READ, 1'b0, 29'd0, 4'd0, 64'd0, 32'hFFFF_FFFF, 6'd0), 1'b1,
				mk_rsp(OUT_NONE, 1'b1, 29'd0, 32'd1, 32'hFFFF_FFFF - 32'd100, 4'd0, 64'd0, 7'd2,
				32'd2, 32'd0)});
		dir_rows.push_back('{mk_req(REQ_READ, 1'b0, 29'd0, 4'd0, 64'd0, 32'd5, 6'd2), 1'b1,
				mk_rsp(OUT_NONE, 1'b0, '0, '0, '0, '0, '0, 7'd2, 32'd2, 32'd0)});
		dir_rows.push_back('{mk_req(REQ_CAPTURE, 1'b0, 29'd0, 4'd3, PAT, 32'd200, 6'd0), 1'b0, '0});
		dir_rows.push_back('{mk_req(REQ_READ, 1'b0, 29'd0, 4'd0, 64'd0, 32'd250, 6'd0), 1'b0, '0});
		dir_rows.push_back('{mk_req(REQ_CAPTURE, 1'b0, 29'h1FFF_FFFF, 4'd9, PAT, 32'd300, 6'd0),
				1'b0, '0});
		dir_rows.push_back('{mk_req(REQ_CAPTURE, 1'b1, 29'h7FF, 4'd8, PAT, 32'd10, 6'd0), 1'b1,
				mk_rsp(OUT_APPENDED, 1'b0, '0, '0, '0, '0, '0, 7'd1, 32'd1, 32'd0)});
		dir_rows.push_back('{mk_req(REQ_CAPTURE, 1'b1, 29'd0, 4'd1, ONES, 32'd20, 6'd0), 1'b0, '0});
		dir_rows.push_back('{mk_req(REQ_CAPTURE, 1'b1, 29'd0, 4'd7, ONES, 32'd30, 6'd0), 1'b0, '0});
		dir_rows.push_back('{mk_req(REQ_READ, 1'b1, 29'd0, 4'd0, 64'd0, 32'd25, 6'd1), 1'b0, '0});
		dir_rows.push_back('{mk_req(REQ_READ, 1'b1, 29'd0, 4'd0, 64'd0, 32'd0, 6'h3F), 1'b0, '0});
		dir_rows.push_back('{mk_req(REQ_UNUSED, 1'b0, 29'h155, 4'd5, PAT, 32'd1, 6'd1), 1'b0, '0});
		dir_rows.push_back('{mk_req(REQ_READ, 1'b0, 29'd0, 4'd0, 64'd0, 32'hFFFF_FFFF, 6'd1),
				1'b0, '0});
		dir_rows.push_back('{mk_req(REQ_CLEAR, 1'b1, 29'h1FFF_FFFF, 4'hF, ONES, 32'hFFFF_FFFF,
				6'h3F), 1'b1, mk_rsp(OUT_NONE, 1'b0, '0, '0, '0, '0, '0, 7'd0, 32'd0, 32'd0)});
		dir_rows.push_back('{mk_req(REQ_READ, 1'b1, 29'd0, 4'd0, 64'd0, 32'd0, 6'd0), 1'b1,
				mk_rsp(OUT_NONE, 1'b0, '0, '0, '0, '0, '0, 7'd0, 32'd0, 32'd0)});
		dir_rows.push_back('{mk_req(REQ_UNUSED, 1'b0, 29'h7FF, 4'd2, PAT, 32'd9, 6'd0), 1'b1,
				mk_rsp(OUT_NONE, 1'b0, '0, '0, '0, '0, '0, 7'd0, 32'd0, 32'd0)});
		dir_rows.push_back('{mk_req(REQ_CAPTURE, 1'b1, 29'h123, 4'd4, PAT, 32'd0, 6'd0), 1'b1,
				mk_rsp(OUT_APPENDED, 1'b0, '0, '0, '0, '0, '0, 7'd1, 32'd1, 32'd0)});
		dir_rows.push_back('{mk_req(REQ_READ, 1'b1, 29'd0, 4'd0, 64'd0, 32'd7, 6'd0), 1'b0, '0});

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) drive_req(dir_rows[i].rq, dir_rows[i].pinned, dir_rows[i].want);

		// random episodes; the first floods new ids so the tables fill and drop early
		n_rand = 0;
		first_ep = 1'b1;
		while (n_rand < RAND_ITEMS) begin
			mode = first_ep ? 1 : $urandom_range(0, 2);
			bus_sel = ($urandom_range(0, 2) == 0) ? -1 : $urandom_range(0, 1);
			ep_len = (mode == 1) ? $urandom_range(110, 200) : $urandom_range(30, 90);
			req_idle_en = ($urandom_range(0, 3) != 0);
			rsp_idle_en = ($urandom_range(0, 3) != 0);
			foreach (id_pool[k]) id_pool[k] = fresh_id();
			if (!first_ep) begin
				drive_req(mk_req(REQ_CLEAR, 1'($urandom), fresh_id(), 4'($urandom),
						{$urandom, $urandom}, $urandom, 6'($urandom)), 1'b0, '0);
				n_rand++;
			end
			first_ep = 1'b0;
			for (int k = 0; k < ep_len && n_rand < RAND_ITEMS; k++) begin
				rand_item(mode, bus_sel);
				if (req_if.data.req_type != REQ_UNUSED) n_rand++;
			end
		end
		req_if.valid <= 1'b0;

		while (pending_rsp_q.size() != 0) @(posedge clk);
		repeat (CIT_MAX_IDS + 8) @(posedge clk);

		$display("run: %0d requests, %0d results; captures %0d appended, %0d updated, %0d dropped",
				n_sent, n_results, n_appended, n_updated, n_dropped);
		$display("run: %0d slot reads (%0d occupied), %0d clears, %0d mismatches",
				n_reads, n_reads_hit, n_clears, err_cnt);
		if (err_cnt == 0) begin
			$display("[can_id_capture_table] OK");
		end else begin
			$display("[can_id_capture_table] ERROR");
		end
		$finish;
	end

endmodule
